// ===== src/pcse_pkg.sv =====
// Package: constants, types and helpers shared by the spline evaluator.
package pcse_pkg;
  localparam int MaxKnots = 64;
  localparam int FracBits = 16;
  localparam int IdxW = $clog2(MaxKnots);
  localparam int CntW = $clog2(MaxKnots + 1);

  localparam logic [1:0] RegLeft = 2'd0;
  localparam logic [1:0] RegInner = 2'd1;
  localparam logic [1:0] RegRight = 2'd2;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  localparam logic CfgKnotCount = 1'b0;
  localparam logic CfgLeftCurv = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [IdxW-1:0] entry_index;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] lin_coef;
    logic signed [31:0] quad_coef;
    logic signed [31:0] cubic_coef;
    logic signed [31:0] query_x;
    logic [1:0]  deriv_order;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [IdxW-1:0] segment;
    logic [1:0]  region;
    logic        saturated;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic f);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    f = 1'b0;
    if (v > hi) begin
      f = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      f = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction
endpackage

// ===== src/pcse_front.sv =====
// Front end: knot table, segment search, coefficient fetch and scaling.
module pcse_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  pcse_pkg::item_t in_item,
  output logic in_busy,
  input  logic [pcse_pkg::CntW-1:0] n_eff,
  input  logic signed [31:0] left_curv,
  output logic job_valid,
  output logic signed [31:0] job_c0,
  output logic signed [31:0] job_c1,
  output logic signed [31:0] job_c2,
  output logic signed [31:0] job_c3,
  output logic [1:0] job_steps,
  output logic signed [32:0] job_h,
  output logic [pcse_pkg::IdxW-1:0] job_seg,
  output logic [1:0] job_region,
  output logic job_flag,
  input  logic job_ready
);
  import pcse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic signed [31:0] x_mem [MaxKnots];
  logic signed [31:0] y_mem [MaxKnots];
  logic signed [31:0] b_mem [MaxKnots];
  logic signed [31:0] c_mem [MaxKnots];
  logic signed [31:0] d_mem [MaxKnots];

  logic [2:0] st_r;
  logic [IdxW-1:0] ra_r;
  logic [CntW-1:0] i_r;
  logic signed [31:0] xr_r, yr_r, br_r, cr_r, dr_r;
  logic signed [31:0] q_r, x0_r;
  logic [1:0] ord_r;
  logic [IdxW-1:0] seg_r;
  logic [1:0] reg_r;
  logic [CntW-1:0] n_r;

  logic wr;
  assign wr = in_valid && !in_busy && in_item.mode == ModeLoad;
  assign in_busy = st_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (wr) begin
      x_mem[in_item.entry_index] <= in_item.knot_x;
      y_mem[in_item.entry_index] <= in_item.knot_y;
      b_mem[in_item.entry_index] <= in_item.lin_coef;
      c_mem[in_item.entry_index] <= in_item.quad_coef;
      d_mem[in_item.entry_index] <= in_item.cubic_coef;
    end
    xr_r <= x_mem[ra_r];
    yr_r <= y_mem[ra_r];
    br_r <= b_mem[ra_r];
    cr_r <= c_mem[ra_r];
    dr_r <= d_mem[ra_r];
  end

  // scan: address i is issued from i_r via ra_r; its data arrives in xr_r in the next cycle
  logic [CntW-1:0] di_r;
  logic dv_r;
  logic signed [32:0] h;
  logic f1, f2, f3, f4;
  logic signed [31:0] c2, d3, d6, cq2, cq;

  always_comb begin
    h = {q_r[31], q_r} - {xr_r[31], xr_r};
    cq = (reg_r == RegLeft) ? left_curv : cr_r;
    cq2 = sat32(66'(cq) * 66'sd2, f1);
    c2 = sat32(66'(cr_r) * 66'sd2, f2);
    d3 = sat32(66'(dr_r) * 66'sd3, f3);
    d6 = sat32(66'(dr_r) * 66'sd6, f4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      dv_r <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_item.mode == ModeEval) begin
            q_r <= in_item.query_x;
            ord_r <= in_item.deriv_order;
            n_r <= n_eff;
            ra_r <= '0;
            i_r <= CntW'(1);
            di_r <= '0;
            dv_r <= 1'b0;
            seg_r <= '0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          dv_r <= 1'b1;
          di_r <= i_r - 1'b1;
          if (i_r < n_r) begin
            ra_r <= i_r[IdxW-1:0];
            i_r <= i_r + 1'b1;
          end
          if (dv_r) begin
            if (di_r == '0) x0_r <= xr_r;
            if (xr_r <= q_r) seg_r <= di_r[IdxW-1:0];
            if (di_r == n_r - 1'b1) begin
              if (q_r < ((di_r == '0) ? xr_r : x0_r)) begin
                reg_r <= RegLeft;
                ra_r <= '0;
                seg_r <= '0;
              end else if (q_r > xr_r) begin
                reg_r <= RegRight;
                ra_r <= di_r[IdxW-1:0];
                seg_r <= di_r[IdxW-1:0];
              end else begin
                reg_r <= RegInner;
                ra_r <= (xr_r <= q_r) ? di_r[IdxW-1:0] : seg_r;
                seg_r <= (xr_r <= q_r) ? di_r[IdxW-1:0] : seg_r;
              end
              st_r <= S_READ;
            end
          end
        end
        S_READ: st_r <= S_WAIT;
        S_WAIT: begin
          job_h <= h;
          job_seg <= seg_r;
          job_region <= reg_r;
          job_c0 <= '0; job_c1 <= '0; job_c2 <= '0; job_c3 <= '0;
          job_flag <= 1'b0;
          job_steps <= 2'd0;
          if (reg_r != RegInner) begin
            case (ord_r)
              2'd0: begin
                job_c0 <= cq; job_c1 <= br_r; job_c2 <= yr_r; job_steps <= 2'd2;
              end
              2'd1: begin
                job_c0 <= cq2; job_c1 <= br_r; job_steps <= 2'd1; job_flag <= f1;
              end
              2'd2: begin
                job_c0 <= cq2; job_flag <= f1;
              end
              default: job_c0 <= '0;
            endcase
          end else begin
            case (ord_r)
              2'd0: begin
                job_c0 <= dr_r; job_c1 <= cr_r; job_c2 <= br_r; job_c3 <= yr_r;
                job_steps <= 2'd3;
              end
              2'd1: begin
                job_c0 <= d3; job_c1 <= c2; job_c2 <= br_r; job_steps <= 2'd2;
                job_flag <= f3 | f2;
              end
              2'd2: begin
                job_c0 <= d6; job_c1 <= c2; job_steps <= 2'd1; job_flag <= f4 | f2;
              end
              default: begin
                job_c0 <= d6; job_flag <= f4;
              end
            endcase
          end
          job_valid <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (job_ready) begin
            job_valid <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/pcse_back.sv =====
// Back end: Horner evaluation, each multiply-add step split into a multiply state and an add state.
module pcse_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  input  logic signed [31:0] job_c0,
  input  logic signed [31:0] job_c1,
  input  logic signed [31:0] job_c2,
  input  logic signed [31:0] job_c3,
  input  logic [1:0] job_steps,
  input  logic signed [32:0] job_h,
  input  logic [pcse_pkg::IdxW-1:0] job_seg,
  input  logic [1:0] job_region,
  input  logic job_flag,
  output logic job_ready,
  output logic res_valid,
  output pcse_pkg::res_t res,
  input  logic res_ready
);
  import pcse_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0] st_r, left_r;
  logic signed [31:0] acc_r, k1_r, k2_r, k3_r;
  logic signed [32:0] h_r;
  logic signed [64:0] p_r;
  logic flag_r;
  logic [IdxW-1:0] seg_r;
  logic [1:0] rg_r;
  logic signed [65:0] sum;
  logic sf;
  logic signed [31:0] nacc;

  assign job_ready = st_r == B_IDLE;
  assign sum = 66'(p_r >>> FracBits) + 66'(k1_r);

  always_comb begin
    nacc = sat32(sum, sf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (job_valid) begin
            acc_r <= job_c0; k1_r <= job_c1; k2_r <= job_c2; k3_r <= job_c3;
            h_r <= job_h; left_r <= job_steps; flag_r <= job_flag;
            seg_r <= job_seg; rg_r <= job_region;
            st_r <= (job_steps == 2'd0) ? B_OUT : B_MUL;
          end
        end
        B_MUL: begin
          p_r <= 65'(acc_r) * 65'(h_r);
          st_r <= B_ADD;
        end
        B_ADD: begin
          acc_r <= nacc;
          flag_r <= flag_r | sf;
          k1_r <= k2_r; k2_r <= k3_r;
          left_r <= left_r - 1'b1;
          st_r <= (left_r == 2'd1) ? B_OUT : B_MUL;
        end
        B_OUT: begin
          if (!res_valid) begin
            res.result_value <= acc_r;
            res.segment <= seg_r;
            res.region <= rg_r;
            res.saturated <= flag_r;
            res_valid <= 1'b1;
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
      if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end
endmodule

// ===== src/piecewise_cubic_spline_eval_top.sv =====
// Top level: configuration registers, front end, back end and result port.
// One item at a time: a load writes one table entry; an evaluation scans the knot
// table one entry a cycle in the front end, then up to 3 Horner steps run in
// the back end, which overlaps the next item's scan. The result register holds
// one finished beat.
module piecewise_cubic_spline_eval_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic in_mode,
  input  logic [5:0] in_entry_index,
  input  logic signed [31:0] in_knot_x,
  input  logic signed [31:0] in_knot_y,
  input  logic signed [31:0] in_lin_coef,
  input  logic signed [31:0] in_quad_coef,
  input  logic signed [31:0] in_cubic_coef,
  input  logic signed [31:0] in_query_x,
  input  logic [1:0] in_deriv_order,
  output logic out_empty,
  input  logic out_pop,
  output logic signed [31:0] out_result_value,
  output logic [5:0] out_segment,
  output logic [1:0] out_region,
  output logic out_saturated,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import pcse_pkg::*;

  logic [6:0] knot_count_r;
  logic signed [31:0] left_curv_r;
  logic [CntW-1:0] n_eff;
  item_t item;
  res_t res;
  logic res_valid, busy;
  logic jv, jr, jf;
  logic signed [31:0] c0, c1, c2, c3;
  logic [1:0] steps, jreg;
  logic signed [32:0] jh;
  logic [IdxW-1:0] jseg;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgLeftCurv) ? left_curv_r : {25'd0, knot_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= 7'd2;
      left_curv_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        CfgKnotCount: knot_count_r <= pwdata[6:0];
        default: left_curv_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    if (knot_count_r < 7'd2) n_eff = CntW'(2);
    else if (knot_count_r > 7'(MaxKnots)) n_eff = CntW'(MaxKnots);
    else n_eff = CntW'(knot_count_r);
  end

  assign item = '{in_mode, in_entry_index, in_knot_x, in_knot_y, in_lin_coef,
                  in_quad_coef, in_cubic_coef, in_query_x, in_deriv_order};
  assign in_full = busy;

  pcse_front u_front (
    .clk, .rst_n, .in_valid(in_push), .in_item(item), .in_busy(busy),
    .n_eff, .left_curv(left_curv_r), .job_valid(jv), .job_c0(c0), .job_c1(c1),
    .job_c2(c2), .job_c3(c3), .job_steps(steps), .job_h(jh), .job_seg(jseg),
    .job_region(jreg), .job_flag(jf), .job_ready(jr)
  );

  pcse_back u_back (
    .clk, .rst_n, .job_valid(jv), .job_c0(c0), .job_c1(c1), .job_c2(c2),
    .job_c3(c3), .job_steps(steps), .job_h(jh), .job_seg(jseg),
    .job_region(jreg), .job_flag(jf), .job_ready(jr), .res_valid, .res,
    .res_ready(out_pop)
  );

  assign out_empty = !res_valid;
  assign out_result_value = res.result_value;
  assign out_segment = res.segment;
  assign out_region = res.region;
  assign out_saturated = res.saturated;
endmodule
